>>> rtl/core/multi_queue_shared_buffer_defines.svh
// Assertion macros for the multi-queue shared buffer checker
`ifndef MULTI_QUEUE_SHARED_BUFFER_DEFINES_SVH
`define MULTI_QUEUE_SHARED_BUFFER_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, disabled while rst_ni is low
`define MQSB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, disabled while rst_ni is low
`define MQSB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/mqsb_pkg.sv
// Package: sizes, codes and control types of the multi-queue shared buffer
`timescale 1ns / 1ps

package mqsb_pkg;

  localparam int SLOTS  = 16;
  localparam int QUEUES = 4;

  localparam int DATA_W = 32;
  localparam int QID_W  = 2;
  localparam int STAT_W = 2;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int PTR_W  = $clog2(SLOTS + 1);
  localparam int QIX_W  = (QUEUES > 1) ? $clog2(QUEUES) : 1;

  localparam logic [PTR_W-1:0] NIL_PTR = PTR_W'(SLOTS);

  localparam logic ACT_ENQ = 1'b0;
  localparam logic ACT_DEQ = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_OVER  = 2'd1;
  localparam logic [STAT_W-1:0] ST_UNDER = 2'd2;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic latch;
    logic look;
    logic enq_link;
    logic deq_link;
    logic load_out;
  } mqsb_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic is_enq;
    logic fail;
  } mqsb_sts_t;

  // Link value of a slot after reset: next slot in order, last slot null
  function automatic logic [PTR_W-1:0] link_init(logic [SLOT_W-1:0] idx);
    logic [PTR_W-1:0] nxt;
    nxt = PTR_W'(idx) + PTR_W'(1);
    return (idx == SLOT_W'(SLOTS - 1)) ? NIL_PTR : nxt;
  endfunction

endpackage

>>> rtl/core/mqsb_if.sv
// Handshake channels: operation words in, result words out
`timescale 1ns / 1ps

interface mqsb_in_if import mqsb_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic                     action;
  logic [QID_W-1:0]         queue_id;
  logic signed [DATA_W-1:0] data_in;

  modport source (output valid, action, queue_id, data_in, input ready);
  modport sink   (input valid, action, queue_id, data_in, output ready);
endinterface

interface mqsb_out_if import mqsb_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [STAT_W-1:0]        status;
  logic signed [DATA_W-1:0] data_out;

  modport source (output valid, status, data_out, input ready);
  modport sink   (input valid, status, data_out, output ready);
endinterface

>>> rtl/core/mqsb_ctrl.sv
// Controller: sequences one operation through lookup, link update (skipped when rejected) and output
`timescale 1ns / 1ps

module mqsb_ctrl import mqsb_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  mqsb_sts_t sts_i,
  output mqsb_cmd_t cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_LOOK     = 5'b00010,
    S_ENQ_LINK = 5'b00100,
    S_DEQ_LINK = 5'b01000,
    S_DONE     = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // Next state and commands
  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    in_ready_o     = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd_o.look = 1'b1;
        if (sts_i.fail) begin
          state_d = S_DONE;
        end else if (sts_i.is_enq) begin
          state_d = S_ENQ_LINK;
        end else begin
          state_d = S_DEQ_LINK;
        end
      end
      S_ENQ_LINK: begin
        cmd_o.enq_link = 1'b1;
        state_d        = S_DONE;
      end
      S_DEQ_LINK: begin
        cmd_o.deq_link = 1'b1;
        state_d        = S_DONE;
      end
      S_DONE: begin
        // Hand the result to the output register once it is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold the output word until taken
  assign out_valid_d = cmd_o.load_out | (out_valid_q & ~out_ready_i);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

>>> rtl/core/mqsb_dp.sv
// Datapath: queue pointers, free list, link and data stores, result registers
`timescale 1ns / 1ps

module mqsb_dp import mqsb_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  mqsb_cmd_t                cmd_i,
  output mqsb_sts_t                sts_o,
  input  logic                     action_i,
  input  logic [QID_W-1:0]         queue_id_i,
  input  logic signed [DATA_W-1:0] data_in_i,
  output logic [STAT_W-1:0]        status_o,
  output logic signed [DATA_W-1:0] data_out_o
);

  // Latched operation
  logic              act_q;
  logic [QID_W-1:0]  qid_q;
  logic [DATA_W-1:0] word_q;
  logic [PTR_W-1:0]  slot_q;

  // Queue and free list pointers
  logic [PTR_W-1:0] head_q [QUEUES];
  logic [PTR_W-1:0] tail_q [QUEUES];
  logic [PTR_W-1:0] free_q;

  // Stores
  logic [PTR_W-1:0]  link_mem [SLOTS];
  logic [SLOTS-1:0]  link_vld_q;
  logic [PTR_W-1:0]  link_rd_q;
  logic [DATA_W-1:0] data_mem [SLOTS];
  logic [DATA_W-1:0] data_rd_q;

  // Results
  logic [STAT_W-1:0] res_status_q;
  logic [DATA_W-1:0] res_data_q;
  logic [STAT_W-1:0] out_status_q;
  logic [DATA_W-1:0] out_data_q;

  logic [QIX_W-1:0]  qix;
  logic [PTR_W-1:0]  head_cur;
  logic [PTR_W-1:0]  tail_cur;
  logic              q_bad;
  logic              is_enq;
  logic              fail;
  logic [PTR_W-1:0]  s_ptr;
  logic [SLOT_W-1:0] link_ra;
  logic              link_we;
  logic [SLOT_W-1:0] link_wa;
  logic [PTR_W-1:0]  link_wd;
  logic              data_we;

  // Decode the latched operation
  assign qix      = QIX_W'(qid_q);
  assign head_cur = head_q[qix];
  assign tail_cur = tail_q[qix];
  assign q_bad    = (int'(qid_q) >= QUEUES);
  assign is_enq   = (act_q == ACT_ENQ);
  assign fail     = is_enq ? (q_bad || (free_q == NIL_PTR))
                           : (q_bad || (head_cur == NIL_PTR));
  assign s_ptr    = is_enq ? free_q : head_cur;

  assign sts_o.is_enq = is_enq;
  assign sts_o.fail   = fail;

  // Link store port: one read, one write per cycle
  assign link_ra = s_ptr[SLOT_W-1:0];

  always_comb begin
    link_we = 1'b0;
    link_wa = slot_q[SLOT_W-1:0];
    link_wd = NIL_PTR;
    if (cmd_i.look && !fail && is_enq) begin
      // new tail slot ends its chain
      link_we = 1'b1;
      link_wa = s_ptr[SLOT_W-1:0];
      link_wd = NIL_PTR;
    end else if (cmd_i.enq_link && (head_cur != NIL_PTR) && (tail_cur != NIL_PTR)) begin
      // old tail points to new slot
      link_we = 1'b1;
      link_wa = tail_cur[SLOT_W-1:0];
      link_wd = slot_q;
    end else if (cmd_i.deq_link) begin
      // freed slot goes on top of the free list
      link_we = 1'b1;
      link_wa = slot_q[SLOT_W-1:0];
      link_wd = free_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    link_rd_q <= link_vld_q[link_ra] ? link_mem[link_ra] : link_init(link_ra);
  end

  // Unwritten link entries read as their reset chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_vld_q <= '0;
    end else if (link_we) begin
      link_vld_q[link_wa] <= 1'b1;
    end
  end

  // Data store
  assign data_we = cmd_i.look && !fail && is_enq;

  always_ff @(posedge clk_i) begin
    if (data_we) begin
      data_mem[s_ptr[SLOT_W-1:0]] <= word_q;
    end
    data_rd_q <= data_mem[s_ptr[SLOT_W-1:0]];
  end

  // Pointer updates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_q <= '0;
      for (int i = 0; i < QUEUES; i++) begin
        head_q[i] <= NIL_PTR;
        tail_q[i] <= NIL_PTR;
      end
    end else if (cmd_i.enq_link) begin
      free_q <= link_rd_q;
      if (head_cur == NIL_PTR) begin
        head_q[qix] <= slot_q;
      end
      tail_q[qix] <= slot_q;
    end else if (cmd_i.deq_link) begin
      head_q[qix] <= link_rd_q;
      free_q      <= slot_q;
    end
  end

  // Operation, result and output registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      act_q  <= action_i;
      qid_q  <= queue_id_i;
      word_q <= data_in_i;
    end
    if (cmd_i.look) begin
      slot_q <= s_ptr;
      if (fail) begin
        res_status_q <= is_enq ? ST_OVER : ST_UNDER;
        res_data_q   <= is_enq ? '0 : '1;
      end else begin
        res_status_q <= ST_OK;
        res_data_q   <= '0;
      end
    end
    if (cmd_i.deq_link) begin
      res_data_q <= data_rd_q;
    end
    if (cmd_i.load_out) begin
      out_status_q <= res_status_q;
      out_data_q   <= res_data_q;
    end
  end

  assign status_o   = out_status_q;
  assign data_out_o = out_data_q;

endmodule

>>> rtl/core/multi_queue_shared_buffer.sv
// Top level: several FIFO queues sharing one linked slot store
//
// Usage:
//   req_i carries one operation word: action (0 enqueue, 1 dequeue), queue_id and
//   data_in. rsp_o returns exactly one result word per operation: status (0 ok,
//   1 overflow, 2 underflow) and data_out (dequeued word, all ones on underflow,
//   zero for an enqueue). Both channels move a word when valid and ready are high.
//   One operation is in flight at a time. A successful operation goes from accept
//   to the result appearing on rsp_o through lookup, link update and result
//   hand-off; a rejected one skips the link update. The next word is accepted in
//   the cycle the result appears, so no new word is taken mid-operation. The link
//   update step is set by the registered read of the link store: the successor of
//   the slot taken is only known in the cycle after lookup. Reset empties all
//   queues and chains every slot into the free list in order; no clearing pass is
//   needed. If rsp_o stalls, the result is held in the output register and one
//   further word may be accepted and processed; it then waits until the output
//   register frees up.
`timescale 1ns / 1ps

module multi_queue_shared_buffer import mqsb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  mqsb_in_if.sink     req_i,
  mqsb_out_if.source  rsp_o
);

  mqsb_cmd_t cmd;
  mqsb_sts_t sts;

  // Sequence the operation
  mqsb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Pointers, stores and result registers
  mqsb_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .action_i   (req_i.action),
    .queue_id_i (req_i.queue_id),
    .data_in_i  (req_i.data_in),
    .status_o   (rsp_o.status),
    .data_out_o (rsp_o.data_out)
  );

endmodule

>>> rtl/core/mqsb_checker.sv
// Port-level checker for the multi-queue shared buffer, bound to the top level
`timescale 1ns / 1ps
`include "multi_queue_shared_buffer_defines.svh"

module mqsb_checker import mqsb_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [STAT_W-1:0] out_status_i,
  input logic [DATA_W-1:0] out_data_i
);

  // Underflow returns all ones, overflow returns zero
  `MQSB_ASSERT_IMP(a_under_data, out_valid_i && (out_status_i == ST_UNDER), out_data_i == {DATA_W{1'b1}}, "underflow word not all ones")
  `MQSB_ASSERT_IMP(a_over_data, out_valid_i && (out_status_i == ST_OVER), out_data_i == '0, "overflow word not zero")

  // One operation at a time: ready drops after an accept
  `MQSB_ASSERT_NXT(a_one_op, in_valid_i && in_ready_i, !in_ready_i, "word accepted while busy")

  // Stalled result holds
  `MQSB_ASSERT_NXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_data_i) && $stable(out_status_i), "stalled result changed")

endmodule

bind multi_queue_shared_buffer mqsb_checker u_mqsb_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (req_i.valid),
  .in_ready_i   (req_i.ready),
  .out_valid_i  (rsp_o.valid),
  .out_ready_i  (rsp_o.ready),
  .out_status_i (rsp_o.status),
  .out_data_i   (rsp_o.data_out)
);
